### rtl/core/mwdiv_pkg.sv
package mwdiv_pkg;

    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR_INVERSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE_SHIFT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_DIVIDE,
        ST_FINISH
    } div_state_t;

endpackage

### rtl/core/multiword_divide_by_limb.sv
// sequence: a beat is accepted only in idle, runs the divide pass, and the finish step
//   registers the result; a held remainder not below the divisor is reduced first
// throughput: one quotient bit per cycle from the restoring subtract unit shared by the
//   reduce and divide passes; zero divisor skips them; finish waits on a held result
// reset: aresetn synchronous active low, clears the sequencer, the held remainder,
//   the output valid and sets the divisor to 1
module multiword_divide_by_limb
    import mwdiv_pkg::*;
#(
    parameter int LIMB_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_W-1:0]    s_dividend_limb,
    input  logic                 s_last_limb,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_W-1:0]    m_quotient_limb,
    output logic [WORD_W-1:0]    m_remainder,
    output logic                 m_final_res
);

    localparam int CNT_W = $clog2(LIMB_BITS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LIMB_BITS - 1);

    div_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [LIMB_BITS-1:0]   rem_reg, rem_next;
    logic [LIMB_BITS-1:0]   quo_reg, quo_next;
    logic [LIMB_BITS-1:0]   limb_reg, limb_next;
    logic [LIMB_BITS-1:0]   den_reg, den_next;
    logic                   last_reg, last_next;
    logic [LIMB_BITS-1:0]   pr_reg, pr_next;
    logic [LIMB_BITS-1:0]   divisor_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [LIMB_BITS-1:0]   m_quo_reg, m_quo_next;
    logic [LIMB_BITS-1:0]   m_rem_reg, m_rem_next;
    logic                   m_final_reg, m_final_next;

    // shared restoring step
    logic [LIMB_BITS-1:0]   step_shift;
    logic [LIMB_BITS:0]     step_diff;
    logic                   step_take;
    logic [LIMB_BITS-1:0]   step_rem;
    logic [LIMB_BITS-1:0]   step_quo;

    always_comb begin
        step_shift = {rem_reg[LIMB_BITS-2:0], quo_reg[LIMB_BITS-1]};
        step_diff  = {rem_reg[LIMB_BITS-1], step_shift} - {1'b0, den_reg};
        step_take  = ~step_diff[LIMB_BITS];
        step_rem   = step_take ? step_diff[LIMB_BITS-1:0] : step_shift;
        step_quo   = {quo_reg[LIMB_BITS-2:0], step_take};
    end

    // only the divisor affects results; the other registers are accepted and dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= LIMB_BITS'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DIVISOR:         divisor_reg <= cfg_wdata[LIMB_BITS-1:0];
                REG_DIVISOR_INVERSE: ;
                REG_NORMALIZE_SHIFT: ;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pr_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pr_reg      <= pr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        limb_reg    <= limb_next;
        den_reg     <= den_next;
        last_reg    <= last_next;
        m_quo_reg   <= m_quo_next;
        m_rem_reg   <= m_rem_next;
        m_final_reg <= m_final_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        limb_next    = limb_reg;
        den_next     = den_reg;
        last_next    = last_reg;
        pr_next      = pr_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_quo_next   = m_quo_reg;
        m_rem_next   = m_rem_reg;
        m_final_next = m_final_reg;
        s_ready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    limb_next = s_dividend_limb[LIMB_BITS-1:0];
                    last_next = s_last_limb;
                    den_next  = divisor_reg;
                    cnt_next  = LAST_CNT;
                    if (divisor_reg == '0) begin
                        rem_next   = '0;
                        quo_next   = '1;
                        state_next = ST_FINISH;
                    end else if (pr_reg >= divisor_reg) begin
                        // divisor changed mid-number: reduce the held remainder first
                        rem_next   = '0;
                        quo_next   = pr_reg;
                        state_next = ST_REDUCE;
                    end else begin
                        rem_next   = pr_reg;
                        quo_next   = s_dividend_limb[LIMB_BITS-1:0];
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_REDUCE: begin
                rem_next = step_rem;
                quo_next = step_quo;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    quo_next   = limb_reg;
                    cnt_next   = LAST_CNT;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                rem_next = step_rem;
                quo_next = step_quo;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_quo_next   = quo_reg;
                    m_rem_next   = last_reg ? rem_reg : '0;
                    m_final_next = last_reg;
                    pr_next      = last_reg ? '0 : rem_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_quotient_limb = WORD_W'(m_quo_reg);
    assign m_remainder     = WORD_W'(m_rem_reg);
    assign m_final_res     = m_final_reg;

`ifndef SYNTHESIS
    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result beat raised outside the finish step");

    a_rem_zero_unless_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_final_res |-> m_remainder == '0)
        else $error("remainder non-zero on a non-final beat");

    a_pr_only_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_FINISH |=> $stable(pr_reg))
        else $error("held remainder changed outside the finish step");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE || state_reg == ST_REDUCE) |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor during a pass");
`endif

endmodule

### tb/multiword_divide_by_limb_tb.sv
module multiword_divide_by_limb_tb
    import mwdiv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMB_BITS      = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    // one limb with a reduce pass in front of it, plus margin
    localparam int DRAIN_CYCLES   = 2 * LIMB_BITS + 16;
    localparam int RANDOM_ITEMS   = 850;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [WORD_W-1:0] LIMB_MASK = {WORD_W{1'b1}} >> (WORD_W - LIMB_BITS);

    typedef struct packed {
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
        logic              final_res;
    } div_result_t;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [WORD_W-1:0]    cfg_wdata       = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [WORD_W-1:0]    s_dividend_limb = '0;
    logic                 s_last_limb     = 1'b0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [WORD_W-1:0]    m_quotient_limb;
    logic [WORD_W-1:0]    m_remainder;
    logic                 m_final_res;

    // predictor state
    logic [WORD_W-1:0] cur_divisor;
    logic [WORD_W-1:0] cur_inverse;
    logic [5:0]        cur_shift;
    logic [WORD_W-1:0] carry_rem;

    div_result_t expected_q[$];

    int  errors        = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  numbers_done  = 0;
    int  zero_div_items = 0;
    int  reduce_items  = 0;
    int  cfg_writes    = 0;
    int  stall_cycles  = 0;
    bit  quiet         = 1'b0;

    multiword_divide_by_limb #(
        .LIMB_BITS(LIMB_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_dividend_limb(s_dividend_limb),
        .s_last_limb    (s_last_limb),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_quotient_limb(m_quotient_limb),
        .m_remainder    (m_remainder),
        .m_final_res    (m_final_res)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return WORD_W'($urandom_range(0, 255));
            3: return {1'b1, 31'($urandom), 32'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_divisor();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            2: return WORD_W'(1);
            3, 4: return WORD_W'($urandom_range(2, 1000));
            5, 6: return WORD_W'($urandom);
            7, 8: return {1'b1, 31'($urandom), 32'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one limb step: (carry : limb) / divisor, carry updated
    function automatic div_result_t divide_step(input logic [WORD_W-1:0] limb_in,
                                                input logic last);
        logic [WORD_W-1:0]   limb;
        logic [WORD_W-1:0]   den;
        logic [WORD_W-1:0]   hi;
        logic [2*WORD_W-1:0] num;
        logic [2*WORD_W-1:0] den_w;
        div_result_t         r;
        limb = limb_in & LIMB_MASK;
        den  = cur_divisor & LIMB_MASK;
        hi   = carry_rem;
        r    = '0;
        if (den == '0) begin
            r.quotient = LIMB_MASK;
            hi = '0;
            zero_div_items++;
        end else begin
            // divisor changed under a held remainder
            if (hi >= den) begin
                hi = hi % den;
                reduce_items++;
            end
            num   = ({{WORD_W{1'b0}}, hi} << LIMB_BITS) | {{WORD_W{1'b0}}, limb};
            den_w = {{WORD_W{1'b0}}, den};
            r.quotient = WORD_W'(num / den_w) & LIMB_MASK;
            hi = WORD_W'(num % den_w);
        end
        r.final_res = last;
        if (last) begin
            r.remainder = hi;
            carry_rem = '0;
        end else begin
            carry_rem = hi;
        end
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DIVISOR:         cur_divisor = val;
            REG_DIVISOR_INVERSE: cur_inverse = val;
            REG_NORMALIZE_SHIFT: cur_shift   = val[5:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic send_limb(input logic [WORD_W-1:0] limb, input logic last);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_dividend_limb <= limb;
        s_last_limb     <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(divide_step(limb, last));
        items_sent++;
    endtask

    // block idle: input lowered, every result back
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic send_number(input int nlimbs, input bit change_mid);
        int cut;
        cut = (nlimbs > 1) ? $urandom_range(1, nlimbs - 1) : -1;
        for (int i = 0; i < nlimbs; i++) begin
            if (change_mid && i == cut) begin
                settle();
                write_reg(REG_DIVISOR, rand_divisor());
            end
            send_limb(rand_word(), i == nlimbs - 1);
        end
    endtask

    task automatic test_reset_defaults();
        // divisor resets to 1, so quotient limbs echo the dividend
        send_limb('1, 1'b0);
        send_limb('0, 1'b0);
        send_limb({1'b1, {(WORD_W-1){1'b0}}}, 1'b1);
        settle();
    endtask

    task automatic test_extreme_divisors();
        write_reg(REG_DIVISOR, '1);
        write_reg(REG_DIVISOR_INVERSE, '0);
        write_reg(REG_NORMALIZE_SHIFT, '0);
        send_limb('1, 1'b1);
        send_limb({{(WORD_W-1){1'b1}}, 1'b0}, 1'b0);
        send_limb('1, 1'b1);
        settle();
        write_reg(REG_DIVISOR, {1'b1, {(WORD_W-1){1'b0}}});
        write_reg(REG_DIVISOR_INVERSE, '1);
        send_limb('1, 1'b0);
        send_limb('1, 1'b1);
        settle();
        // shift written with all bits set; the predictor keeps only the low six, the block drops it
        write_reg(REG_DIVISOR, WORD_W'(3));
        write_reg(REG_NORMALIZE_SHIFT, '1);
        write_reg(REG_DIVISOR_INVERSE, {$urandom, $urandom});
        write_reg(REG_UNUSED, '1);
        send_limb('1, 1'b0);
        send_limb('0, 1'b1);
        settle();
    endtask

    task automatic test_zero_divisor();
        write_reg(REG_DIVISOR, '0);
        send_limb({$urandom, $urandom}, 1'b0);
        send_limb('1, 1'b1);
        settle();
    endtask

    task automatic test_divisor_change_mid();
        write_reg(REG_DIVISOR, '1);
        send_limb({{(WORD_W-1){1'b1}}, 1'b0}, 1'b0);
        settle();
        // held remainder far above the new divisor
        write_reg(REG_DIVISOR, WORD_W'(10));
        send_limb(WORD_W'(123), 1'b0);
        settle();
        write_reg(REG_DIVISOR, '0);
        send_limb(WORD_W'(5), 1'b0);
        settle();
        write_reg(REG_DIVISOR, WORD_W'(7));
        send_limb(WORD_W'(1000), 1'b0);
        settle();
        write_reg(REG_DIVISOR, WORD_W'(5));
        send_limb('1, 1'b1);
        settle();
    endtask

    task automatic test_random_numbers(input int target);
        int nlimbs;
        int r;
        while (items_sent < target) begin
            settle();
            quiet = ($urandom_range(0, 7) == 0);
            write_reg(REG_DIVISOR, rand_divisor());
            r = $urandom_range(0, 9);
            if (r < 3) write_reg(REG_DIVISOR_INVERSE, {$urandom, $urandom});
            if (r == 3 || r == 4) write_reg(REG_NORMALIZE_SHIFT, {$urandom, $urandom});
            if (r == 5) write_reg(REG_UNUSED, {$urandom, $urandom});
            repeat ($urandom_range(1, 3)) begin
                nlimbs = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                      : $urandom_range(1, 4);
                send_number(nlimbs, $urandom_range(0, 7) == 0);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        cur_divisor = WORD_W'(1);
        cur_inverse = '0;
        cur_shift   = '0;
        carry_rem   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_extreme_divisors();
        test_zero_divisor();
        test_divisor_change_mid();
        test_random_numbers(RANDOM_ITEMS);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0) begin
            errors++;
            $display("%0d expected result beats never arrived", expected_q.size());
        end
        $display("sent %0d limbs in %0d dividends, %0d config writes, %0d result beats",
                 items_sent, numbers_done, cfg_writes, results_seen);
        $display("limbs with zero divisor: %0d, with held remainder reduced: %0d, errors: %0d",
                 zero_div_items, reduce_items, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // result side back-pressure
    initial begin : ready_gen
        int hold;
        forever begin
            @(posedge aclk);
            if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
                hold = pick_gap();
                repeat (hold) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        div_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_final_res === 1'b1) numbers_done++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: quotient %h remainder %h final %b",
                             m_quotient_limb, m_remainder, m_final_res);
            end else begin
                want = expected_q.pop_front();
                if (m_quotient_limb !== want.quotient || m_remainder !== want.remainder ||
                    m_final_res !== want.final_res) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch on beat %0d:", results_seen);
                        $display("  quotient  exp %h got %h", want.quotient, m_quotient_limb);
                        $display("  remainder exp %h got %h", want.remainder, m_remainder);
                        $display("  final     exp %b got %b", want.final_res, m_final_res);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         stall_cycles, expected_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

### multiword_divide_by_limb.f
rtl/core/mwdiv_pkg.sv
rtl/core/multiword_divide_by_limb.sv
tb/multiword_divide_by_limb_tb.sv
